### hdl/assert_macros.svh
// Assertion macros for the RTL files (included by gsu_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/gsu_pkg.sv
// Shared types and constants of the segment union-merge block.
`default_nettype none
package gsu_pkg;
	localparam int unsigned MAX_VERTICES_DEF = 65536;
	localparam int VERT_W     = 16;
	localparam int WGT_W      = 16;
	localparam int SIZE_W     = 17;
	localparam int THR_W      = 32;
	localparam int MC_W       = 24;
	localparam int VC_W       = 17;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_MERGE_CONSTANT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 1'b1;

	localparam logic [MC_W-1:0] MERGE_CONSTANT_RST = 24'd76800;
	localparam logic [VC_W-1:0] VERTEX_COUNT_RST   = 17'd65536;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic walk_a_start;
		logic walk_b_start;
		logic walk_step;
		logic root_a;
		logic root_b;
		logic decide;
		logic write_gone;
		logic write_keep;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic va_ok;
		logic edge_ok;
		logic clr_last;
		logic at_root;
		logic can_merge;
		logic div_done;
		logic out_free;
	} dp_sts_t;
endpackage
`default_nettype wire

### hdl/gsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### hdl/gsu_div.sv
// Restoring divider, one quotient bit per cycle: constant over merged size.
`default_nettype none
module gsu_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [gsu_pkg::MC_W-1:0]  dividend,
	input  wire logic [gsu_pkg::SIZE_W-1:0] divisor,
	output logic                           busy,
	output logic      [gsu_pkg::MC_W-1:0]  quotient
);
	import gsu_pkg::*;
	localparam int CW = $clog2(MC_W + 1);

	logic [SIZE_W-1:0] rem_q;
	logic [MC_W-1:0]   quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [SIZE_W:0]   r_sh;
	logic [SIZE_W+1:0] diff;
	logic              ge;

	assign r_sh = {rem_q, quo_q[MC_W-1]};
	assign diff = {1'b0, r_sh} - {2'b00, divisor};
	assign ge   = !diff[SIZE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(MC_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SIZE_W-1:0] : r_sh[SIZE_W-1:0];
			quo_q <= {quo_q[MC_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

### hdl/gsu_dp.sv
// Datapath: forest memory, root walk registers, merge arithmetic, output register.
`default_nettype none
module gsu_dp #(
	parameter int unsigned MAX_VERTICES = gsu_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire gsu_pkg::dp_cmd_t               cmd,
	output gsu_pkg::dp_sts_t                    sts,
	input  wire logic                           cfg_we,
	input  wire logic [gsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gsu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [gsu_pkg::OP_W-1:0]       op,
	input  wire logic [gsu_pkg::VERT_W-1:0]     vertex_a,
	input  wire logic [gsu_pkg::VERT_W-1:0]     vertex_b,
	input  wire logic [gsu_pkg::WGT_W-1:0]      edge_weight,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                merged,
	output logic      [gsu_pkg::VERT_W-1:0]     root_vertex,
	output logic      [gsu_pkg::SIZE_W-1:0]     component_size
);
	import gsu_pkg::*;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int WW = AW + SIZE_W + THR_W;
	localparam int unsigned ACT_RST = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;

	logic [OP_W-1:0]   op_q;
	logic [VERT_W-1:0] va_q, vb_q;
	logic [WGT_W-1:0]  w_q;
	logic [AW-1:0]     cur_q, ra_q, rb_q;
	logic [SIZE_W-1:0] sa_q, sb_q, sum_q;
	logic [THR_W-1:0]  ta_q, tb_q;
	logic              keep_b_q;
	logic [VC_W-1:0]   cnt_q, active_q, vc_q;
	logic [MC_W-1:0]   mc_q;
	logic              merged_q;
	logic              out_valid_q, out_merged_q;
	logic [VERT_W-1:0] out_root_q;
	logic [SIZE_W-1:0] out_size_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WW-1:0]     ram_wdata, ram_rdata;
	logic [AW-1:0]     rd_parent, keep_v, gone_v;
	logic [SIZE_W-1:0] rd_size;
	logic [THR_W-1:0]  rd_thr, thr_new;
	logic [THR_W:0]    thr_sum;
	logic [MC_W-1:0]   quo;
	logic              div_busy, va_ok, clr_in;

	assign rd_parent = ram_rdata[WW-1 -: AW];
	assign rd_size   = ram_rdata[SIZE_W+THR_W-1 -: SIZE_W];
	assign rd_thr    = ram_rdata[THR_W-1:0];
	assign keep_v    = keep_b_q ? rb_q : ra_q;
	assign gone_v    = keep_b_q ? ra_q : rb_q;
	assign thr_sum   = {{(THR_W+1-WGT_W){1'b0}}, w_q} + {{(THR_W+1-MC_W){1'b0}}, quo};
	assign thr_new   = thr_sum[THR_W] ? {THR_W{1'b1}} : thr_sum[THR_W-1:0];
	assign va_ok     = {1'b0, va_q} < {{(VERT_W+1-VC_W){1'b0}}, active_q};
	assign clr_in    = cnt_q < active_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(cnt_q);
		ram_wdata = {AW'(cnt_q), SIZE_W'(1), {(THR_W-MC_W){1'b0}}, mc_q};
		if (cmd.clr_step) begin
			ram_we = clr_in;
		end else if (cmd.write_gone) begin
			ram_we    = 1'b1;
			ram_waddr = gone_v;
			ram_wdata = keep_b_q ? {keep_v, sa_q, ta_q} : {keep_v, sb_q, tb_q};
		end else if (cmd.write_keep) begin
			ram_we    = 1'b1;
			ram_waddr = keep_v;
			ram_wdata = {keep_v, sum_q, thr_new};
		end
	end

	assign ram_re    = cmd.walk_a_start | cmd.walk_b_start | cmd.walk_step;
	assign ram_raddr = cmd.walk_a_start ? AW'(va_q) :
		cmd.walk_b_start ? AW'(vb_q) : rd_parent;

	gsu_ram #(.WIDTH(WW), .DEPTH(MAX_VERTICES)) u_forest (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	gsu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.write_gone), .dividend(mc_q),
		.divisor(sum_q), .busy(div_busy), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q        <= MERGE_CONSTANT_RST;
			vc_q        <= VERTEX_COUNT_RST;
			active_q    <= VC_W'(ACT_RST);
			cnt_q       <= '0;
			merged_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MERGE_CONSTANT: mc_q <= cfg_data[MC_W-1:0];
					CFG_VERTEX_COUNT:   vc_q <= cfg_data[VC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				merged_q <= 1'b0;
				cnt_q    <= '0;
				if (op == OP_START) begin
					active_q <= (32'(vc_q) > MAX_VERTICES) ? VC_W'(MAX_VERTICES) : vc_q;
				end
			end else if (cmd.clr_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.write_keep) begin
				merged_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op;
			va_q <= vertex_a;
			vb_q <= vertex_b;
			w_q  <= edge_weight;
		end
		if (cmd.walk_a_start) begin
			cur_q <= AW'(va_q);
		end else if (cmd.walk_b_start) begin
			cur_q <= AW'(vb_q);
		end else if (cmd.walk_step) begin
			cur_q <= rd_parent;
		end
		if (cmd.root_a) begin
			ra_q <= cur_q;
			sa_q <= rd_size;
			ta_q <= rd_thr;
		end
		if (cmd.root_b) begin
			rb_q <= cur_q;
			sb_q <= rd_size;
			tb_q <= rd_thr;
		end
		if (cmd.decide) begin
			keep_b_q <= sb_q > sa_q;
			sum_q    <= sa_q + sb_q;
		end
		if (cmd.load_out) begin
			out_merged_q <= merged_q;
			if (op_q == OP_START) begin
				out_root_q <= va_q;
				out_size_q <= va_ok ? SIZE_W'(1) : '0;
			end else if (va_ok) begin
				out_root_q <= merged_q ? VERT_W'(keep_v) : VERT_W'(ra_q);
				out_size_q <= merged_q ? sum_q : sa_q;
			end else begin
				out_root_q <= va_q;
				out_size_q <= '0;
			end
		end
	end

	always_comb begin
		sts.is_start  = op_q == OP_START;
		sts.va_ok     = va_ok;
		sts.edge_ok   = (op_q == OP_EDGE) && va_ok &&
			({1'b0, vb_q} < {{(VERT_W+1-VC_W){1'b0}}, active_q});
		sts.clr_last  = ({1'b0, cnt_q} + 1'b1) >= {1'b0, active_q};
		sts.at_root   = rd_parent == cur_q;
		sts.can_merge = (ra_q != rb_q) &&
			({{(THR_W-WGT_W){1'b0}}, w_q} <= ta_q) &&
			({{(THR_W-WGT_W){1'b0}}, w_q} <= tb_q);
		sts.div_done  = !div_busy;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign merged         = out_merged_q;
	assign root_vertex    = out_root_q;
	assign component_size = out_size_q;
endmodule
`default_nettype wire

### hdl/gsu_ctrl.sv
// Controller state machine: clearing sweep, root walks, merge and result hand-off.
`default_nettype none
`include "assert_macros.svh"
module gsu_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gsu_pkg::dp_sts_t sts,
	output gsu_pkg::dp_cmd_t      cmd
);
	import gsu_pkg::*;

	typedef enum logic [10:0] {
		ST_CLR_RST = 11'b000_0000_0001,
		ST_IDLE    = 11'b000_0000_0010,
		ST_DISP    = 11'b000_0000_0100,
		ST_CLEAR   = 11'b000_0000_1000,
		ST_WALK_A  = 11'b000_0001_0000,
		ST_WALK_B  = 11'b000_0010_0000,
		ST_DECIDE  = 11'b000_0100_0000,
		ST_GONE    = 11'b000_1000_0000,
		ST_DIVW    = 11'b001_0000_0000,
		ST_KEEP    = 11'b010_0000_0000,
		ST_FIN     = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_RST;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLR_RST: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.is_start) begin
					state_d = ST_CLEAR;
				end else if (sts.va_ok) begin
					cmd.walk_a_start = 1'b1;
					state_d          = ST_WALK_A;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_FIN;
			end
			ST_WALK_A: begin
				if (sts.at_root) begin
					cmd.root_a = 1'b1;
					if (sts.edge_ok) begin
						cmd.walk_b_start = 1'b1;
						state_d          = ST_WALK_B;
					end else begin
						state_d = ST_FIN;
					end
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_WALK_B: begin
				if (sts.at_root) begin
					cmd.root_b = 1'b1;
					state_d    = ST_DECIDE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.can_merge ? ST_GONE : ST_FIN;
			end
			ST_GONE: begin
				// link the smaller root (b on a size tie) under the kept one, start the divide
				cmd.write_gone = 1'b1;
				state_d        = ST_DIVW;
			end
			ST_DIVW: begin
				if (sts.div_done) state_d = ST_KEEP;
			end
			ST_KEEP: begin
				cmd.write_keep = 1'b1;
				state_d        = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_NEXT(a_gone_then_div, clk, arst_n, state_q == ST_GONE, state_q == ST_DIVW, "divide did not follow link write")
	`ASSERT_IMPL(a_load_free, clk, arst_n, cmd.load_out, sts.out_free, "result loaded over an untaken beat")
	`ASSERT_IMPL(a_keep_done, clk, arst_n, cmd.write_keep, sts.div_done, "threshold written before quotient ready")
endmodule
`default_nettype wire

### hdl/graph_segment_union_merge.sv
// Top level of the graph segmentation union-merge core.
// Usage: one beat on the input channel (op, vertex_a, vertex_b, edge_weight)
// gives exactly one beat on the output channel (merged, root_vertex,
// component_size). op 0 starts a new graph, 1 processes an edge, 2 (or 3)
// finds the root of vertex_a. Items are handled one at a time.
// A find walks from vertex_a up to its root; an edge walks both roots
// and, when it merges, runs the divider for the new threshold. A start
// runs the clearing sweep of the forest memory over the active vertex
// count, one entry a cycle.
// The next item can be taken in the cycle after a result is loaded.
// After reset the same sweep runs over min(vertex_count, MAX_VERTICES)
// entries (65536 by default) with in_ready low.
// The result sits in an output register: in_ready returns as soon as the
// result is loaded, so the next item is taken while out_valid waits for
// out_ready. A stalled receiver holds the block only when a second result
// is ready to be loaded.
// Configuration: cfg_we/cfg_index/cfg_data, written while idle.
`default_nettype none
module graph_segment_union_merge #(
	parameter int unsigned MAX_VERTICES = gsu_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [gsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gsu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [gsu_pkg::OP_W-1:0]       op,
	input  wire logic [gsu_pkg::VERT_W-1:0]     vertex_a,
	input  wire logic [gsu_pkg::VERT_W-1:0]     vertex_b,
	input  wire logic [gsu_pkg::WGT_W-1:0]      edge_weight,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                merged,
	output logic      [gsu_pkg::VERT_W-1:0]     root_vertex,
	output logic      [gsu_pkg::SIZE_W-1:0]     component_size
);
	import gsu_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gsu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	gsu_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .vertex_a(vertex_a), .vertex_b(vertex_b), .edge_weight(edge_weight),
		.out_valid(out_valid), .out_ready(out_ready), .merged(merged),
		.root_vertex(root_vertex), .component_size(component_size)
	);
endmodule
`default_nettype wire

### tb/graph_segment_union_merge_tb.sv
// Self-checking testbench for the graph segmentation union-merge core.
`timescale 1ns / 100ps
module graph_segment_union_merge_tb;
	import gsu_pkg::*;

	localparam logic [OP_W-1:0] OP_FIND     = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND_ALT = 2'd3;
	localparam int FOREST_DEPTH = 65536;
	localparam int STALL_LIMIT  = 250000;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [VERT_W-1:0] va;
		logic [VERT_W-1:0] vb;
		logic [WGT_W-1:0]  w;
	} graph_op_t;

	typedef struct {
		logic              merged;
		logic [VERT_W-1:0] root;
		logic [SIZE_W-1:0] size;
	} union_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [OP_W-1:0]       op;
	logic [VERT_W-1:0]     vertex_a;
	logic [VERT_W-1:0]     vertex_b;
	logic [WGT_W-1:0]      edge_weight;
	logic                  out_valid;
	logic                  out_ready;
	logic                  merged;
	logic [VERT_W-1:0]     root_vertex;
	logic [SIZE_W-1:0]     component_size;

	graph_segment_union_merge uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .vertex_a(vertex_a), .vertex_b(vertex_b), .edge_weight(edge_weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.merged(merged), .root_vertex(root_vertex), .component_size(component_size)
	);

	// predictor state
	logic [VERT_W-1:0] parent_of [FOREST_DEPTH];
	logic [SIZE_W-1:0] size_of   [FOREST_DEPTH];
	logic [THR_W-1:0]  thresh_of [FOREST_DEPTH];
	logic [MC_W-1:0]   scale_c;
	logic [VC_W-1:0]   count_reg;
	int unsigned       live_count;

	graph_op_t     pending_ops [$];
	union_result_t expected_results [$];
	int            errors;
	int            beats_in;
	int            beats_out;
	int            quiet_cycles;
	int            hold_left;
	bit            held_once;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void reset_forest();
		live_count = (count_reg > FOREST_DEPTH) ? FOREST_DEPTH : count_reg;
		for (int v = 0; v < FOREST_DEPTH; v++) begin
			parent_of[v] = v[VERT_W-1:0];
			size_of[v] = 1;
			thresh_of[v] = {8'd0, scale_c};
		end
	endfunction

	function automatic int unsigned find_root(int unsigned v);
		int unsigned steps;
		int unsigned p;
		steps = 0;
		while (parent_of[v] != v && steps < live_count) begin
			p = parent_of[v];
			if (p >= live_count)
				break;
			v = p;
			steps++;
		end
		return v;
	endfunction

	function automatic union_result_t apply_graph_op(graph_op_t g);
		union_result_t r;
		int unsigned ra, rb, keep, gone;
		logic [63:0] t;
		r.merged = 1'b0;
		r.root = g.va;
		r.size = '0;
		if (g.op == OP_START) begin
			reset_forest();
		end else if (g.op == OP_EDGE && g.va < live_count && g.vb < live_count) begin
			ra = find_root(g.va);
			rb = find_root(g.vb);
			if (ra != rb && g.w <= thresh_of[ra] && g.w <= thresh_of[rb]) begin
				keep = ra;
				gone = rb;
				if (size_of[rb] > size_of[ra]) begin
					keep = rb;
					gone = ra;
				end
				parent_of[gone] = keep[VERT_W-1:0];
				size_of[keep] = size_of[keep] + size_of[gone];
				t = 64'(g.w) + 64'(scale_c / size_of[keep]);
				if (t > 64'hFFFF_FFFF)
					t = 64'hFFFF_FFFF;
				thresh_of[keep] = t[THR_W-1:0];
				r.merged = 1'b1;
			end
		end
		if (g.va < live_count) begin
			ra = find_root(g.va);
			r.root = ra[VERT_W-1:0];
			r.size = size_of[ra];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch beat %0d: %s got 0x%0h expected 0x%0h", beats_out, what, got, want);
		errors++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		graph_op_t g;
		bit calm;
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_FIND;
			vertex_a <= '0;
			vertex_b <= '0;
			edge_weight <= '0;
		end else begin
			if (in_valid && in_ready) begin
				g.op = op;
				g.va = vertex_a;
				g.vb = vertex_b;
				g.w = edge_weight;
				expected_results.push_back(apply_graph_op(g));
				beats_in++;
			end
			calm = (beats_in >= 450 && beats_in < 650);
			if (!in_valid || in_ready) begin
				if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
					g = pending_ops.pop_front();
					in_valid <= 1'b1;
					op <= g.op;
					vertex_a <= g.va;
					vertex_b <= g.vb;
					edge_weight <= g.w;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		union_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result beat %0d", beats_out);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (merged !== e.merged)
						report_mismatch("merged", 32'(merged), 32'(e.merged));
					if (root_vertex !== e.root)
						report_mismatch("root_vertex", 32'(root_vertex), 32'(e.root));
					if (component_size !== e.size)
						report_mismatch("component_size", 32'(component_size), 32'(e.size));
				end
				beats_out++;
			end
			// one long receiver hold-off so the block backs up into its input
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (beats_out == 300 && !held_once) begin
				held_once <= 1'b1;
				hold_left <= 180;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (beats_in >= 450 && beats_in < 650) || $urandom_range(0, 99) >= 33;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_op(logic [OP_W-1:0] o, int va, int vb, int w);
		graph_op_t g;
		g.op = o;
		g.va = va[VERT_W-1:0];
		g.vb = vb[VERT_W-1:0];
		g.w = w[WGT_W-1:0];
		pending_ops.push_back(g);
	endtask

	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MERGE_CONSTANT)
			scale_c = value[MC_W-1:0];
		else
			count_reg = value[VC_W-1:0];
	endtask

	// mostly sorted edges within range, with finds, stray vertices and noise
	task automatic push_random_graph(int n, int span, bit with_starts);
		int w, step, sel;
		w = 0;
		step = $urandom_range(0, 3) == 0 ? 4000 : $urandom_range(1, 600);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 72) begin
				w = w + $urandom_range(0, step);
				if (w > 65535)
					w = $urandom_range(0, 255);
				push_op(OP_EDGE, $urandom_range(0, span - 1), $urandom_range(0, span - 1), w);
			end else if (sel < 84) begin
				push_op($urandom_range(0, 1) ? OP_FIND : OP_FIND_ALT,
					$urandom_range(0, span - 1), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			end else if (sel < 92) begin
				push_op(OP_EDGE, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			end else if (sel < 97 || !with_starts) begin
				push_op($urandom_range(0, 3), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				if (pending_ops[$].op == OP_START && !with_starts)
					pending_ops[$].op = OP_FIND;
			end else begin
				push_op(OP_START, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
				w = 0;
			end
		end
	endtask

	task automatic run_phase(int unsigned c, int unsigned vc, int n);
		write_reg(CFG_MERGE_CONSTANT, c);
		write_reg(CFG_VERTEX_COUNT, vc);
		push_op(OP_START, $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
		push_random_graph(n, vc > 64 ? 64 : vc, vc < 1000);
		wait_drained();
	endtask

	initial begin
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		held_once = 1'b0;
		quiet_cycles = 0;
		cfg_we = 1'b0;
		cfg_index = CFG_MERGE_CONSTANT;
		cfg_data = '0;
		scale_c = MERGE_CONSTANT_RST;
		count_reg = VERTEX_COUNT_RST;
		reset_forest();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// let the post-reset clearing sweep finish
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);

		// full-size forest under reset settings
		push_op(OP_FIND, 0, 0, 0);
		push_op(OP_FIND, 65535, 65535, 65535);
		push_op(OP_FIND_ALT, 7, 3, 9);
		push_op(OP_EDGE, 0, 1, 0);
		push_op(OP_EDGE, 1, 0, 0);
		push_op(OP_EDGE, 2, 65535, 65535);
		push_op(OP_FIND, 65535, 0, 0);
		push_op(OP_EDGE, 3, 3, 65535);
		push_op(OP_EDGE, 65535, 0, 65535);
		push_op(OP_FIND_ALT, 2, 0, 0);
		wait_drained();

		// tiny graph, zero scale: thresholds reject any positive weight
		write_reg(CFG_MERGE_CONSTANT, 0);
		write_reg(CFG_VERTEX_COUNT, 5);
		push_op(OP_START, 4, 0, 0);
		push_op(OP_START, 5, 0, 0);
		push_op(OP_EDGE, 0, 1, 1);
		push_op(OP_EDGE, 0, 1, 0);
		push_op(OP_EDGE, 2, 1, 0);
		push_op(OP_EDGE, 3, 4, 0);
		push_op(OP_EDGE, 7, 1, 0);
		push_op(OP_EDGE, 1, 9, 0);
		push_op(OP_FIND, 4, 0, 0);
		push_op(OP_FIND, 5, 0, 0);
		push_op(OP_EDGE, 3, 0, 0);
		wait_drained();

		run_phase(0, 2, 60);
		run_phase(24'hFFFFFF, 5, 140);
		run_phase(76800, 64, 160);
		run_phase(300, 16, 140);
		run_phase($urandom_range(0, 24'hFFFFFF), $urandom_range(2, 200), 150);
		run_phase($urandom_range(0, 20000), $urandom_range(2, 40), 150);
		run_phase(24'hFFFFFF, 64, 150);
		run_phase($urandom_range(0, 24'hFFFFFF), 65536, 120);

		wait_drained();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
